FILE: hdl/pixel_fuzzy_logic_alu_assert.svh
// Assertion macros for the pixel fuzzy logic ALU.
// Used by the top level only; needs no package.
`ifndef PIXEL_FUZZY_LOGIC_ALU_ASSERT_SVH
`define PIXEL_FUZZY_LOGIC_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the cycle after the antecedent.
`define PFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel_fuzzy_logic_alu: next-cycle check failed");
// Consequent must hold in the same cycle as the antecedent.
`define PFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_fuzzy_logic_alu: same-cycle check failed");
`else
`define PFL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define PFL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/pfl_pkg.sv
// Shared constants and operation codes for the pixel fuzzy logic ALU.
// No dependencies; imported by pfl_ops and pixel_fuzzy_logic_alu.
`timescale 1ns / 1ps
`default_nettype none

package pfl_pkg;

    localparam int PIX_W = 8;
    localparam int CMD_W = 5;

    // Full-scale pixel value.
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Operation codes; codes above CMD_SUBLVL yield zero.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 5'd0,
        CMD_SUB       = 5'd1,
        CMD_ABSDIFF   = 5'd2,
        CMD_MIN       = 5'd3,
        CMD_MAX       = 5'd4,
        CMD_ALGPROD   = 5'd5,
        CMD_ALGSUM    = 5'd6,
        CMD_BOUNDPROD = 5'd7,
        CMD_DRSUM     = 5'd8,
        CMD_DRPROD    = 5'd9,
        CMD_NEG       = 5'd10,
        CMD_TOZERO    = 5'd11,
        CMD_TOZEROINV = 5'd12,
        CMD_BIN       = 5'd13,
        CMD_BININV    = 5'd14,
        CMD_ADDLVL    = 5'd15,
        CMD_SUBLVL    = 5'd16
    } t_cmd;

endpackage

`default_nettype wire

FILE: hdl/pfl_ops.sv
// Combinational pixel operator unit: all seventeen per-pixel operations.
// Depends on pfl_pkg for widths, the full-scale constant and opcodes.
`timescale 1ns / 1ps
`default_nettype none

module pfl_ops
    import pfl_pkg::*;
(
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire logic [PIX_W-1:0] i_pixel_a,
    input  wire logic [PIX_W-1:0] i_pixel_b,
    input  wire logic [PIX_W-1:0] i_level,
    output logic      [PIX_W-1:0] o_pixel_out
);

    logic [PIX_W:0]     sum_ab;
    logic [PIX_W:0]     sum_al;
    logic               a_gt_b;
    logic               a_gt_l;
    logic [2*PIX_W-1:0] prod_ab;
    logic [2*PIX_W:0]   prod_p1;
    logic [2*PIX_W:0]   quot_sum;
    logic [PIX_W-1:0]   quot;
    logic [PIX_W:0]     alg_sum;
    logic [PIX_W:0]     bound_sum;
    logic [PIX_W:0]     lvl_sum;

    // Sums and compares used by the operations below.
    assign sum_ab = {1'b0, i_pixel_a} + {1'b0, i_pixel_b};
    assign sum_al = {1'b0, i_pixel_a} + {1'b0, i_level};
    assign a_gt_b = (i_pixel_a > i_pixel_b);
    assign a_gt_l = (i_pixel_a > i_level);

    // Algebraic product (a*b + 1) / 255. For x below 65536,
    // floor(x / 255) equals (x + (x >> 8) + 1) >> 8; the +1 is folded into x.
    assign prod_ab  = i_pixel_a * i_pixel_b;
    assign prod_p1  = {1'b0, prod_ab} + 17'd1;
    assign quot_sum = prod_p1 + {8'd0, prod_p1[2*PIX_W:PIX_W]} + 17'd1;
    assign quot     = quot_sum[2*PIX_W-1:PIX_W];

    // Algebraic sum keeps the low byte of a + b - product.
    assign alg_sum   = sum_ab - {1'b0, quot};
    assign bound_sum = sum_ab - {1'b0, PIX_MAX};
    assign lvl_sum   = sum_al;

    // Operation select.
    always_comb begin
        case (i_cmd)
            CMD_ADD:       o_pixel_out = sum_ab[PIX_W] ? PIX_MAX : sum_ab[PIX_W-1:0];
            CMD_SUB:       o_pixel_out = a_gt_b ? (i_pixel_a - i_pixel_b) : '0;
            CMD_ABSDIFF:   o_pixel_out = a_gt_b ? (i_pixel_a - i_pixel_b)
                                                : (i_pixel_b - i_pixel_a);
            CMD_MIN:       o_pixel_out = a_gt_b ? i_pixel_b : i_pixel_a;
            CMD_MAX:       o_pixel_out = a_gt_b ? i_pixel_a : i_pixel_b;
            CMD_ALGPROD:   o_pixel_out = quot;
            CMD_ALGSUM:    o_pixel_out = alg_sum[PIX_W-1:0];
            CMD_BOUNDPROD: o_pixel_out = sum_ab[PIX_W] ? bound_sum[PIX_W-1:0] : '0;
            CMD_DRSUM: begin
                if (i_pixel_a == '0) begin
                    o_pixel_out = i_pixel_b;
                end else if (i_pixel_b == '0) begin
                    o_pixel_out = i_pixel_a;
                end else begin
                    o_pixel_out = PIX_MAX;
                end
            end
            CMD_DRPROD: begin
                if (i_pixel_a == PIX_MAX) begin
                    o_pixel_out = i_pixel_b;
                end else if (i_pixel_b == PIX_MAX) begin
                    o_pixel_out = i_pixel_a;
                end else begin
                    o_pixel_out = '0;
                end
            end
            CMD_NEG:       o_pixel_out = PIX_MAX - i_pixel_a;
            CMD_TOZERO:    o_pixel_out = a_gt_l ? i_pixel_a : '0;
            CMD_TOZEROINV: o_pixel_out = a_gt_l ? '0 : i_pixel_a;
            CMD_BIN:       o_pixel_out = a_gt_l ? PIX_MAX : '0;
            CMD_BININV:    o_pixel_out = a_gt_l ? '0 : PIX_MAX;
            CMD_ADDLVL:    o_pixel_out = lvl_sum[PIX_W] ? PIX_MAX : lvl_sum[PIX_W-1:0];
            CMD_SUBLVL:    o_pixel_out = a_gt_l ? (i_pixel_a - i_level) : '0;
            default:       o_pixel_out = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/pixel_fuzzy_logic_alu.sv
// Pixel fuzzy logic ALU top level: input register, operator unit, result register.
// Depends on pfl_pkg, pfl_ops and pixel_fuzzy_logic_alu_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// One pixel operation per clock. A transfer is taken on every edge where start is
// high; busy is always low, so the source never waits. The result appears on
// o_pixel_out with o_done high for one cycle, after passing the input register,
// then the operator logic into the result register. The receiver cannot stall and
// must take the result in that cycle. The level register is written through
// i_level_we and i_level; the user must write it only while no operation is in
// flight, and the block itself does not enforce this. It resets to zero.

`include "pixel_fuzzy_logic_alu_assert.svh"

module pixel_fuzzy_logic_alu
    import pfl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire logic [PIX_W-1:0] i_pixel_a,
    input  wire logic [PIX_W-1:0] i_pixel_b,
    input  wire logic             i_level_we,
    input  wire logic [PIX_W-1:0] i_level,
    output logic                  o_done,
    output logic      [PIX_W-1:0] o_pixel_out
);

    logic             r_in_valid;
    logic [CMD_W-1:0] r_cmd;
    logic [PIX_W-1:0] r_pixel_a;
    logic [PIX_W-1:0] r_pixel_b;
    logic [PIX_W-1:0] r_level;
    logic             r_done;
    logic [PIX_W-1:0] r_pixel_out;
    logic [PIX_W-1:0] n_pixel_out;

    // The block never holds off a transfer.
    assign busy = 1'b0;

    // Control state and the level register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
            r_level    <= '0;
        end else begin
            r_in_valid <= start & ~busy;
            r_done     <= r_in_valid;
            if (i_level_we) begin
                r_level <= i_level;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_cmd     <= i_cmd;
            r_pixel_a <= i_pixel_a;
            r_pixel_b <= i_pixel_b;
        end
    end

    // Operator logic between the two register stages.
    pfl_ops u_ops (
        .i_cmd       (r_cmd),
        .i_pixel_a   (r_pixel_a),
        .i_pixel_b   (r_pixel_b),
        .i_level     (r_level),
        .o_pixel_out (n_pixel_out)
    );

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_pixel_out <= n_pixel_out;
        end
    end

    assign o_done      = r_done;
    assign o_pixel_out = r_pixel_out;

    // Every accepted transfer produces exactly one result, through the input and result registers.
    `PFL_ASSERT_NEXT(a_accept_to_stage, i_clk, i_rst_n, start, r_in_valid)
    `PFL_ASSERT_NEXT(a_stage_to_done, i_clk, i_rst_n, r_in_valid, o_done)
    `PFL_ASSERT_NOW(a_done_has_source, i_clk, i_rst_n, o_done, $past(r_in_valid))
    `PFL_ASSERT_NOW(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)

endmodule

`default_nettype wire

FILE: tb/sv/pixel_fuzzy_logic_alu_tb.sv
// Self-checking testbench for the pixel fuzzy logic ALU: directed and random pixel
// operations at several level settings and idle ratios, checked against a local predictor.
// Depends on pfl_pkg and the pixel_fuzzy_logic_alu top level.
`timescale 1ns / 1ps

module pixel_fuzzy_logic_alu_tb;
    import pfl_pkg::*;

    // Opcodes outside the defined set; the block returns zero for them.
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 5'd17;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 5'd31;

    // Cycles to let pass after the last result before touching the level register.
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [PIX_W-1:0] pixel_a;
        logic [PIX_W-1:0] pixel_b;
        logic [PIX_W-1:0] pixel_out;
    } t_pixel_job;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [CMD_W-1:0] i_cmd;
    logic [PIX_W-1:0] i_pixel_a;
    logic [PIX_W-1:0] i_pixel_b;
    logic             i_level_we;
    logic [PIX_W-1:0] i_level;
    logic             o_done;
    logic [PIX_W-1:0] o_pixel_out;

    // Expected pixels in transfer order, and the level the block should hold.
    t_pixel_job       pending_pixels[$];
    logic [PIX_W-1:0] model_level;

    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned n_level_writes;
    int unsigned n_errors;

    pixel_fuzzy_logic_alu u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_pixel_a   (i_pixel_a),
        .i_pixel_b   (i_pixel_b),
        .i_level_we  (i_level_we),
        .i_level     (i_level),
        .o_done      (o_done),
        .o_pixel_out (o_pixel_out)
    );

    always #5 i_clk = ~i_clk;

    // Global watchdog; a correct run ends far earlier.
    initial begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding", pending_pixels.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Expected output pixel for one operation at the given level.
    function automatic logic [PIX_W-1:0] predict_pixel(input logic [CMD_W-1:0] cmd,
                                                       input logic [PIX_W-1:0] a,
                                                       input logic [PIX_W-1:0] b,
                                                       input logic [PIX_W-1:0] lvl);
        int unsigned ua;
        int unsigned ub;
        int unsigned ul;
        int unsigned full;
        int unsigned prod;
        ua   = a;
        ub   = b;
        ul   = lvl;
        full = PIX_MAX;
        prod = (ua * ub + 1) / full;
        case (cmd)
            CMD_ADD:       return (ua + ub > full) ? PIX_MAX : PIX_W'(ua + ub);
            CMD_SUB:       return (ua > ub) ? PIX_W'(ua - ub) : '0;
            CMD_ABSDIFF:   return (ua > ub) ? PIX_W'(ua - ub) : PIX_W'(ub - ua);
            CMD_MIN:       return (ua < ub) ? a : b;
            CMD_MAX:       return (ua > ub) ? a : b;
            CMD_ALGPROD:   return PIX_W'(prod);
            CMD_ALGSUM:    return PIX_W'(ua + ub - prod);
            CMD_BOUNDPROD: return (ua + ub > full) ? PIX_W'(ua + ub - full) : '0;
            CMD_DRSUM:     return (ua == 0) ? b : ((ub == 0) ? a : PIX_MAX);
            CMD_DRPROD:    return (ua == full) ? b : ((ub == full) ? a : '0);
            CMD_NEG:       return PIX_W'(full - ua);
            // A pixel equal to the level is not above it.
            CMD_TOZERO:    return (ua > ul) ? a : '0;
            CMD_TOZEROINV: return (ua > ul) ? '0 : a;
            CMD_BIN:       return (ua > ul) ? PIX_MAX : '0;
            CMD_BININV:    return (ua > ul) ? '0 : PIX_MAX;
            CMD_ADDLVL:    return (ua + ul > full) ? PIX_MAX : PIX_W'(ua + ul);
            CMD_SUBLVL:    return (ua > ul) ? PIX_W'(ua - ul) : '0;
            default:       return '0;
        endcase
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Compare every result strobe with the oldest pending expectation.
    always @(posedge i_clk) begin
        t_pixel_job job;
        if (i_rst_n && o_done) begin
            if (pending_pixels.size() == 0) begin
                report_error($sformatf("unexpected result pixel %0d", o_pixel_out));
            end else begin
                job = pending_pixels.pop_front();
                n_checked++;
                if (o_pixel_out !== job.pixel_out) begin
                    report_error($sformatf("cmd %0d a %0d b %0d: pixel_out %0d, expected %0d",
                                           job.cmd, job.pixel_a, job.pixel_b,
                                           o_pixel_out, job.pixel_out));
                end
            end
        end
    end

    // Present one operation and hold it until the block takes the transfer.
    task automatic send_pixel(input logic [CMD_W-1:0] cmd,
                              input logic [PIX_W-1:0] a,
                              input logic [PIX_W-1:0] b);
        t_pixel_job job;
        @(negedge i_clk);
        start     <= 1'b1;
        i_cmd     <= cmd;
        i_pixel_a <= a;
        i_pixel_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        job.cmd       = cmd;
        job.pixel_a   = a;
        job.pixel_b   = b;
        job.pixel_out = predict_pixel(cmd, a, b, model_level);
        pending_pixels.push_back(job);
        n_sent++;
    endtask

    // Sender idle cycles: each cycle is idle with the given percentage.
    task automatic idle_sender(input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending and wait until every result has come back.
    task automatic drain_pipeline;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the level register while nothing is in flight.
    task automatic program_level(input logic [PIX_W-1:0] value);
        drain_pipeline();
        @(negedge i_clk);
        i_level_we <= 1'b1;
        i_level    <= value;
        @(negedge i_clk);
        i_level_we  <= 1'b0;
        i_level     <= $urandom_range(255);
        model_level = value;
        n_level_writes++;
    endtask

    // Half the time extremes and values around the level, otherwise uniform.
    function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] lvl);
        case ($urandom_range(9))
            0:       return '0;
            1:       return PIX_MAX;
            2:       return lvl;
            3:       return lvl + 8'd1;
            4:       return lvl - 8'd1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Two-operand operations at and near their extremes, negation and undefined opcodes, at the reset level of zero.
    task automatic test_directed_ops;
        send_pixel(CMD_ADD, PIX_MAX, PIX_MAX);
        send_pixel(CMD_ADD, 8'd0, 8'd0);
        send_pixel(CMD_SUB, 8'd0, PIX_MAX);
        send_pixel(CMD_SUB, PIX_MAX, 8'd0);
        send_pixel(CMD_ABSDIFF, 8'd0, PIX_MAX);
        send_pixel(CMD_MIN, 8'd7, 8'd200);
        send_pixel(CMD_MAX, 8'd7, 8'd200);
        send_pixel(CMD_ALGPROD, PIX_MAX, PIX_MAX);
        send_pixel(CMD_ALGSUM, PIX_MAX, PIX_MAX);
        send_pixel(CMD_BOUNDPROD, 8'd128, 8'd128);
        send_pixel(CMD_BOUNDPROD, 8'd100, 8'd100);
        // Drastic sum and product: pass-through sides, then both operands ordinary.
        send_pixel(CMD_DRSUM, 8'd0, 8'd77);
        send_pixel(CMD_DRSUM, 8'd5, 8'd9);
        send_pixel(CMD_DRPROD, 8'd33, PIX_MAX);
        send_pixel(CMD_DRPROD, 8'd33, 8'd44);
        send_pixel(CMD_NEG, 8'd0, PIX_MAX);
        // Undefined opcodes return zero.
        send_pixel(CMD_UNDEF_LO, PIX_MAX, PIX_MAX);
        send_pixel(CMD_UNDEF_HI, PIX_MAX, PIX_MAX);
    endtask

    // Level operations, including a pixel exactly at the level.
    task automatic test_level_ops;
        program_level(8'd100);
        send_pixel(CMD_TOZERO, 8'd100, 8'd0);
        send_pixel(CMD_TOZERO, 8'd101, 8'd0);
        send_pixel(CMD_TOZEROINV, 8'd100, PIX_MAX);
        send_pixel(CMD_BIN, 8'd101, 8'd0);
        send_pixel(CMD_BININV, 8'd100, 8'd0);
        send_pixel(CMD_ADDLVL, 8'd200, 8'd0);
        send_pixel(CMD_SUBLVL, 8'd50, PIX_MAX);
    endtask

    // Random operations over two level settings at one sender idle ratio.
    task automatic test_random_phase(input int unsigned idle_pct,
                                     input int unsigned first_seg,
                                     input int unsigned n_items);
        logic [CMD_W-1:0] cmd;
        logic [PIX_W-1:0] lvl;
        for (int seg = 0; seg < 2; seg++) begin
            case (first_seg + seg)
                0:       lvl = '0;
                1:       lvl = PIX_MAX;
                2:       lvl = 8'd1;
                3:       lvl = 8'd254;
                default: lvl = PIX_W'($urandom_range(255));
            endcase
            program_level(lvl);
            for (int n = 0; n < n_items; n++) begin
                if ($urandom_range(9) == 0) begin
                    cmd = CMD_W'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
                end else begin
                    cmd = CMD_W'($urandom_range(CMD_SUBLVL));
                end
                idle_sender(idle_pct);
                send_pixel(cmd, pick_pixel(lvl), pick_pixel(lvl));
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = '0;
        i_pixel_a      = '0;
        i_pixel_b      = '0;
        i_level_we     = 1'b0;
        i_level        = '0;
        model_level    = '0;
        n_sent         = 0;
        n_checked      = 0;
        n_level_writes = 0;
        n_errors       = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_level_ops();
        // Back-to-back, heavy idling, back-to-back again, moderate idling.
        test_random_phase(0, 0, 125);
        test_random_phase(49, 2, 125);
        test_random_phase(0, 4, 125);
        test_random_phase(28, 6, 125);

        drain_pipeline();

        $display("Summary: %0d pixel transfers, %0d results checked, %0d level writes",
                 n_sent, n_checked, n_level_writes);
        $display("Covered all operations, undefined opcodes, level extremes, idle 0/28/49%%");
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
